// ===== hw/rtl/hsv_to_rgb_converter_macros.svh =====
// Assertion macros shared by the HSV to RGB converter.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// The property must hold in the same cycle that the condition is seen.
`define HSV_IMPLIES(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// The signal must keep its value in the cycle after the condition is seen.
`define HSV_HOLDS(label, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

// ===== hw/rtl/hsv_pkg.sv =====
// Constants and types for the HSV to RGB converter.
package hsv_pkg;

  localparam int unsigned HUE_W       = 13;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned REM_W       = 10;
  localparam int unsigned SECTOR_SPAN = 960;
  localparam int unsigned CHAN_MAX    = 255;
  localparam int unsigned QT_DEN      = CHAN_MAX * SECTOR_SPAN;
  localparam int unsigned SECTOR_MAX  = ((1 << HUE_W) - 1) / SECTOR_SPAN;
  localparam int unsigned SECTOR_CNT  = 6;

  localparam int unsigned PROD_W  = 18;
  localparam int unsigned NQ_W    = 26;
  localparam int unsigned NP_W    = 16;

  // Reciprocal scaling for the constant divisions.
  localparam int unsigned QT_SHIFT = NQ_W;
  localparam int unsigned QT_RECIP = (1 << QT_SHIFT) / QT_DEN;
  localparam int unsigned P_SHIFT  = NP_W;
  localparam int unsigned P_RECIP  = (1 << P_SHIFT) / CHAN_MAX;
  localparam int unsigned QT_EST_W = QT_SHIFT + 9;
  localparam int unsigned P_EST_W  = P_SHIFT + 9;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

endpackage

// ===== hw/rtl/hsv_to_rgb_converter.sv =====
// Five-stage pipelined HSV to RGB pixel converter, top level.
//
// Converts one pixel per clock while rgb_stall is low, from hue (1/16 degree),
// saturation and brightness to 8-bit red, green and blue by the hexcone rule with
// truncating integer division. A pixel passes in order through hue sector split,
// saturation products, brightness products, reciprocal quotient estimates, and
// quotient correction with channel selection into the output register. The pipeline
// accepts a new beat every cycle while hsv_stall is low; a stage holds only when the
// stage after it is full and held, so bubbles close up under output stall. Hue values
// at or above the full circle wrap once.
module hsv_to_rgb_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        hsv_valid,
  output logic        hsv_stall,
  input  logic [12:0] hue,
  input  logic [7:0]  saturation,
  input  logic [7:0]  brightness,
  output logic        rgb_valid,
  input  logic        rgb_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  import hsv_pkg::*;

  `include "hsv_to_rgb_converter_macros.svh"

  logic en1, en2, en3, en4, en5;

  // Stage 1: sector and remainder.
  logic                s1_vld;
  sector_t             s1_sector;
  logic [REM_W-1:0]    s1_rem;
  logic [CHAN_W-1:0]   s1_s, s1_v;

  // Stage 2: saturation products.
  logic                s2_vld;
  sector_t             s2_sector;
  logic [PROD_W-1:0]   s2_sq, s2_st;
  logic [CHAN_W-1:0]   s2_sc, s2_v;

  // Stage 3: numerators.
  logic                s3_vld;
  sector_t             s3_sector;
  logic [NQ_W-1:0]     s3_nq, s3_nt;
  logic [NP_W-1:0]     s3_np;
  logic [CHAN_W-1:0]   s3_v;

  // Stage 4: quotient estimates.
  logic                s4_vld;
  sector_t             s4_sector;
  logic [NQ_W-1:0]     s4_nq, s4_nt;
  logic [NP_W-1:0]     s4_np;
  logic [CHAN_W-1:0]   s4_eq, s4_et, s4_ep, s4_v;

  // Output stage.
  logic [CHAN_W-1:0]   out_v;

  assign en5 = !rgb_valid || !rgb_stall;
  assign en4 = !s4_vld || en5;
  assign en3 = !s3_vld || en4;
  assign en2 = !s2_vld || en3;
  assign en1 = !s1_vld || en2;
  assign hsv_stall = !en1;

  // Sector split over the whole 13-bit hue range, then fold the wrapped sectors.
  logic [3:0]       raw_sec;
  logic [HUE_W-1:0] rem_full;
  logic [3:0]       fold_sec;

  always_comb begin
    raw_sec = '0;
    for (int k = 1; k <= int'(SECTOR_MAX); k++) begin
      raw_sec = raw_sec + 4'(hue >= HUE_W'(k * SECTOR_SPAN));
    end
    rem_full = hue - HUE_W'(int'(raw_sec) * SECTOR_SPAN);
    fold_sec = (raw_sec >= 4'(SECTOR_CNT)) ? raw_sec - 4'(SECTOR_CNT) : raw_sec;
  end

  logic [QT_EST_W-1:0] est_q, est_t;
  logic [P_EST_W-1:0]  est_p;

  always_comb begin
    est_q = QT_EST_W'(s3_nq) * QT_EST_W'(QT_RECIP);
    est_t = QT_EST_W'(s3_nt) * QT_EST_W'(QT_RECIP);
    est_p = P_EST_W'(s3_np) * P_EST_W'(P_RECIP);
  end

  // Quotient correction: the estimate is at most one below the true quotient.
  logic [NQ_W-1:0]   res_q, res_t;
  logic [NP_W-1:0]   res_p;
  logic [CHAN_W-1:0] fin_q, fin_t, fin_p;
  logic [CHAN_W-1:0] red_next, green_next, blue_next;

  always_comb begin
    res_q = s4_nq - NQ_W'(NQ_W'(s4_eq) * NQ_W'(QT_DEN));
    res_t = s4_nt - NQ_W'(NQ_W'(s4_et) * NQ_W'(QT_DEN));
    res_p = s4_np - NP_W'(NP_W'(s4_ep) * NP_W'(CHAN_MAX));
    fin_q = s4_eq + CHAN_W'(res_q >= NQ_W'(QT_DEN));
    fin_t = s4_et + CHAN_W'(res_t >= NQ_W'(QT_DEN));
    fin_p = s4_ep + CHAN_W'(res_p >= NP_W'(CHAN_MAX));
    case (s4_sector)
      SEC_RY: begin
        red_next = s4_v;  green_next = fin_t; blue_next = fin_p;
      end
      SEC_YG: begin
        red_next = fin_q; green_next = s4_v;  blue_next = fin_p;
      end
      SEC_GC: begin
        red_next = fin_p; green_next = s4_v;  blue_next = fin_t;
      end
      SEC_CB: begin
        red_next = fin_p; green_next = fin_q; blue_next = s4_v;
      end
      SEC_BM: begin
        red_next = fin_t; green_next = fin_p; blue_next = s4_v;
      end
      default: begin
        red_next = s4_v;  green_next = fin_p; blue_next = fin_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld    <= 1'b0;
      s2_vld    <= 1'b0;
      s3_vld    <= 1'b0;
      s4_vld    <= 1'b0;
      rgb_valid <= 1'b0;
    end else begin
      if (en1) s1_vld <= hsv_valid;
      if (en2) s2_vld <= s1_vld;
      if (en3) s3_vld <= s2_vld;
      if (en4) s4_vld <= s3_vld;
      if (en5) rgb_valid <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_sector <= sector_t'(fold_sec[2:0]);
      s1_rem    <= rem_full[REM_W-1:0];
      s1_s      <= saturation;
      s1_v      <= brightness;
    end
    if (en2) begin
      s2_sector <= s1_sector;
      s2_sq     <= PROD_W'(s1_s) * PROD_W'(s1_rem);
      s2_st     <= PROD_W'(s1_s) * (PROD_W'(SECTOR_SPAN) - PROD_W'(s1_rem));
      s2_sc     <= CHAN_W'(CHAN_MAX) - s1_s;
      s2_v      <= s1_v;
    end
    if (en3) begin
      s3_sector <= s2_sector;
      s3_nq     <= NQ_W'(s2_v) * (NQ_W'(QT_DEN) - NQ_W'(s2_sq));
      s3_nt     <= NQ_W'(s2_v) * (NQ_W'(QT_DEN) - NQ_W'(s2_st));
      s3_np     <= NP_W'(s2_v) * NP_W'(s2_sc);
      s3_v      <= s2_v;
    end
    if (en4) begin
      s4_sector <= s3_sector;
      s4_nq     <= s3_nq;
      s4_nt     <= s3_nt;
      s4_np     <= s3_np;
      s4_eq     <= est_q[QT_SHIFT +: CHAN_W];
      s4_et     <= est_t[QT_SHIFT +: CHAN_W];
      s4_ep     <= est_p[P_SHIFT +: CHAN_W];
      s4_v      <= s3_v;
    end
    if (en5) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
      out_v <= s4_v;
    end
  end

  `HSV_IMPLIES(a_est_close, s4_vld, (res_q < NQ_W'(2 * QT_DEN)) && (res_t < NQ_W'(2 * QT_DEN)) && (res_p < NP_W'(2 * CHAN_MAX)), "Quotient estimate is more than one below the true quotient.")
  `HSV_IMPLIES(a_peak_chan, rgb_valid, (red == out_v) || (green == out_v) || (blue == out_v), "No output channel equals the brightness.")
  `HSV_IMPLIES(a_chan_bound, rgb_valid, (red <= out_v) && (green <= out_v) && (blue <= out_v), "An output channel exceeds the brightness.")
  `HSV_HOLDS(a_s1_hold, s1_vld && !en2, s1_rem, "First stage changed while the next stage was held.")

endmodule

// ===== dv/tb_hsv_to_rgb_converter.sv =====
// Self-checking testbench for the HSV to RGB converter with a scoreboard and random flow control.
module tb_hsv_to_rgb_converter;

  localparam int unsigned HUE_FULL = hsv_pkg::SECTOR_CNT * hsv_pkg::SECTOR_SPAN;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          RANDOM_PIXELS = 1250;

  typedef struct packed {
    logic [12:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pixel_t;

  class hsv_rgb_scoreboard;
    pixel_t rgb_due[$];
    int     errors;
    int     pixels;
    int     results;
    int     grays;
    int     wraps;
    int     sector_hits[hsv_pkg::SECTOR_CNT];

    function automatic pixel_t hexcone_rgb(logic [12:0] h_in, logic [7:0] s_in,
                                           logic [7:0] v_in);
      int unsigned     h;
      int unsigned     s;
      int unsigned     v;
      int unsigned     rem;
      int unsigned     p;
      int unsigned     q;
      int unsigned     t;
      hsv_pkg::sector_t sec;
      pixel_t          px;
      h = 32'(h_in);
      s = 32'(s_in);
      v = 32'(v_in);
      px.hue = h_in;
      px.sat = s_in;
      px.val = v_in;
      if (h >= HUE_FULL) begin
        h = h - HUE_FULL;
      end
      sec = hsv_pkg::sector_t'(h / hsv_pkg::SECTOR_SPAN);
      rem = h % hsv_pkg::SECTOR_SPAN;
      p = (v * (hsv_pkg::CHAN_MAX - s)) / hsv_pkg::CHAN_MAX;
      q = (v * (hsv_pkg::QT_DEN - s * rem)) / hsv_pkg::QT_DEN;
      t = (v * (hsv_pkg::QT_DEN - s * (hsv_pkg::SECTOR_SPAN - rem))) / hsv_pkg::QT_DEN;
      if (s == 0) begin
        px.red = 8'(v);
        px.green = 8'(v);
        px.blue = 8'(v);
      end else begin
        case (sec)
          hsv_pkg::SEC_RY: begin px.red = 8'(v); px.green = 8'(t); px.blue = 8'(p); end
          hsv_pkg::SEC_YG: begin px.red = 8'(q); px.green = 8'(v); px.blue = 8'(p); end
          hsv_pkg::SEC_GC: begin px.red = 8'(p); px.green = 8'(v); px.blue = 8'(t); end
          hsv_pkg::SEC_CB: begin px.red = 8'(p); px.green = 8'(q); px.blue = 8'(v); end
          hsv_pkg::SEC_BM: begin px.red = 8'(t); px.green = 8'(p); px.blue = 8'(v); end
          default:         begin px.red = 8'(v); px.green = 8'(p); px.blue = 8'(q); end
        endcase
      end
      return px;
    endfunction

    function void note_pixel(logic [12:0] h, logic [7:0] s, logic [7:0] v);
      int unsigned hw;
      hw = (h >= HUE_FULL) ? 32'(h) - HUE_FULL : 32'(h);
      rgb_due.push_back(hexcone_rgb(h, s, v));
      pixels++;
      if (s == 0) grays++;
      if (h >= HUE_FULL) wraps++;
      sector_hits[hw / hsv_pkg::SECTOR_SPAN]++;
    endfunction

    function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pixel_t     want;
      logic [7:0] got[3];
      logic [7:0] exp[3];
      string      names[3];
      results++;
      if (rgb_due.size() == 0) begin
        $display("%0t: unexpected beat red=%0d green=%0d blue=%0d", $time, r, g, b);
        errors++;
        return;
      end
      want = rgb_due.pop_front();
      got = '{r, g, b};
      exp = '{want.red, want.green, want.blue};
      names = '{"red", "green", "blue"};
      foreach (got[i]) begin
        if (got[i] !== exp[i]) begin
          $display("%0t: %s mismatch for hue=%0d sat=%0d val=%0d: expected %0d, got %0d",
                   $time, names[i], want.hue, want.sat, want.val, exp[i], got[i]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return rgb_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        hsv_valid = 1'b0;
  logic        hsv_stall;
  logic [12:0] hue = '0;
  logic [7:0]  saturation = '0;
  logic [7:0]  brightness = '0;
  logic        rgb_valid;
  logic        rgb_stall = 1'b0;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  hsv_rgb_scoreboard sb = new();
  bit                idle_on = 1'b0;
  int                quiet_cycles = 0;

  hsv_to_rgb_converter u_top (
    .clk        (clk),
    .rst        (rst),
    .hsv_valid  (hsv_valid),
    .hsv_stall  (hsv_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .rgb_valid  (rgb_valid),
    .rgb_stall  (rgb_stall),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int stall_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic send_pixel(input logic [12:0] h, input logic [7:0] s, input logic [7:0] v,
                            input int gap);
    @(negedge clk);
    if (gap > 0) begin
      hsv_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    hsv_valid <= 1'b1;
    hue <= h;
    saturation <= s;
    brightness <= v;
    do @(posedge clk); while (hsv_stall);
    sb.note_pixel(h, s, v);
  endtask

  task automatic drain_pixels();
    @(negedge clk);
    hsv_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic send_random_pixel();
    logic [12:0] h;
    logic [7:0]  s;
    logic [7:0]  v;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 8) h = 13'($urandom_range(HUE_FULL + 1, 8191));
    else if (r < 16) h = 13'($urandom_range(0, 6) * hsv_pkg::SECTOR_SPAN);
    else if (r < 22) h = 13'($urandom_range(1, 6) * hsv_pkg::SECTOR_SPAN - 1);
    else h = 13'($urandom_range(0, HUE_FULL));
    r = $urandom_range(0, 99);
    s = (r < 8) ? 8'd0 : (r < 16) ? 8'd255 : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    v = (r < 6) ? 8'd0 : (r < 14) ? 8'd255 : 8'($urandom_range(0, 255));
    send_pixel(h, s, v, sender_gap());
  endtask

  initial begin : rgb_sink
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        rgb_stall <= 1'b1;
        hold--;
      end else if (idle_on && $urandom_range(0, 99) < 25) begin
        rgb_stall <= 1'b1;
        hold = stall_length() - 1;
      end else begin
        rgb_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rgb_valid && !rgb_stall) begin
      sb.check_pixel(red, green, blue);
    end
  end

  always @(posedge clk) begin
    if ((hsv_valid && !hsv_stall) || (rgb_valid && !rgb_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d pixels outstanding", $time, QUIET_LIMIT,
               sb.pending());
      $display("tb_hsv_to_rgb_converter failed");
      $finish;
    end
  end

  initial begin : stimulus
    int dir_hue[];
    int dir_sat[];
    int dir_val[];
    dir_hue = '{0, 5760, 5761, 8191, 959, 960, 1920, 2880, 3840, 4800,
                5759, 480, 1234, 2000, 0, 4321, 7000, 6720, 2500, 3000};
    dir_sat = '{255, 255, 200, 255, 255, 255, 128, 255, 77, 255,
                255, 0, 0, 255, 0, 1, 170, 255, 85, 254};
    dir_val = '{255, 255, 180, 255, 255, 255, 200, 100, 255, 255,
                255, 200, 0, 0, 255, 254, 85, 255, 170, 1};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_hue[i]) begin
      send_pixel(13'(dir_hue[i]), 8'(dir_sat[i]), 8'(dir_val[i]), 0);
    end
    drain_pixels();

    for (int blk = 0; blk < RANDOM_PIXELS / 125; blk++) begin
      idle_on = (blk % 3 != 2);
      for (int n = 0; n < 125; n++) begin
        send_random_pixel();
      end
      if (blk == 4) begin
        drain_pixels();
      end
    end
    idle_on = 1'b0;

    drain_pixels();
    repeat (10) @(posedge clk);

    $display("Converted %0d pixels into %0d results: %0d gray, %0d at or past the full circle.",
             sb.pixels, sb.results, sb.grays, sb.wraps);
    $display("Pixels per hue sector: %0d %0d %0d %0d %0d %0d", sb.sector_hits[0],
             sb.sector_hits[1], sb.sector_hits[2], sb.sector_hits[3], sb.sector_hits[4],
             sb.sector_hits[5]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_hsv_to_rgb_converter passed");
    end else begin
      $display("tb_hsv_to_rgb_converter failed");
    end
    $finish;
  end

endmodule
